/* rtl/jkv_pkg.sv */
// ----------------------------------------------------------------------------
// jkv_pkg
// Shared types, widths and constants of the JSON key/value extractor.
// ----------------------------------------------------------------------------
package jkv_pkg;

    localparam int CH_W        = 8;
    localparam int LEN_W       = 12;
    localparam int KLEN_W      = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int KEY_WORDS   = 4;
    localparam int KEY_CHARS   = KEY_WORDS * CFG_DATA_W / CH_W;
    localparam int KEY_MAX_DEF = 32;
    localparam int VALUE_MAX   = 4095;

    localparam logic [LEN_W-1:0] VALUE_LIMIT_RST = 12'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT = 3'd5;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;

    typedef logic [KEY_WORDS-1:0][CFG_DATA_W-1:0] key_words_t;

    typedef struct packed {
        logic [CH_W-1:0]  value_byte;
        logic             is_status;
        logic             found;
        logic [LEN_W-1:0] value_length;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

/* rtl/jkv_key_match.sv */
// ----------------------------------------------------------------------------
// jkv_key_match
// Window of recent text bytes and parallel compare against the quoted key.
// ----------------------------------------------------------------------------
module jkv_key_match #(
    parameter int KEY_MAX = jkv_pkg::KEY_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       process,
    input  logic [jkv_pkg::CH_W-1:0]   ch,
    input  jkv_pkg::key_words_t        key_words,
    input  logic [jkv_pkg::KLEN_W-1:0] key_length,
    output logic                       match
);
    import jkv_pkg::*;

    localparam int IW = $clog2(KEY_MAX + 2);

    logic [CH_W-1:0] win_reg  [KEY_MAX+1];
    logic [CH_W-1:0] win_next [KEY_MAX+1];
    logic [IW-1:0]   n;
    logic [KEY_MAX+1:1] ok;

    function automatic logic [CH_W-1:0] key_char(key_words_t kw, int idx);
        logic [KEY_WORDS*CFG_DATA_W-1:0] flat;
        flat = kw;
        if (idx < 0 || idx >= KEY_CHARS) begin
            return '0;
        end
        return flat[idx*CH_W +: CH_W];
    endfunction

    always_comb
    begin
        if (int'(key_length) > KEY_MAX) begin
            n = IW'(KEY_MAX);
        end else begin
            n = IW'(key_length);
        end
    end

    always_comb
    begin
        for (int j = 1; j <= KEY_MAX + 1; j++) begin
            if (j > int'(n) + 1) begin
                ok[j] = 1'b1;
            end else if (j == int'(n) + 1) begin
                ok[j] = (win_reg[j-1] == CH_QUOTE);
            end else begin
                ok[j] = (win_reg[j-1] == key_char(key_words, int'(n) - j));
            end
        end
    end

    assign match = (ch == CH_QUOTE) && (&ok);

    always_comb
    begin
        win_next = win_reg;
        if (process) begin
            if (ch == CH_NUL) begin
                for (int k = 0; k <= KEY_MAX; k++) begin
                    win_next[k] = '0;
                end
            end else begin
                win_next[0] = ch;
                for (int k = 1; k <= KEY_MAX; k++) begin
                    win_next[k] = win_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= KEY_MAX; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            win_reg <= win_next;
        end
    end

endmodule

/* rtl/jkv_parser.sv */
// ----------------------------------------------------------------------------
// jkv_parser
// Phase tracking after the key and generation of value and status results.
// ----------------------------------------------------------------------------
module jkv_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      process,
    input  logic [jkv_pkg::CH_W-1:0]  ch,
    input  logic                      match,
    input  logic [jkv_pkg::LEN_W-1:0] value_limit,
    output jkv_pkg::push_t            push
);
    import jkv_pkg::*;

    localparam logic [2:0] PH_SEARCH = 3'd0;
    localparam logic [2:0] PH_COLON  = 3'd1;
    localparam logic [2:0] PH_PREVAL = 3'd2;
    localparam logic [2:0] PH_STRING = 3'd3;
    localparam logic [2:0] PH_ESCAPE = 3'd4;
    localparam logic [2:0] PH_NEST   = 3'd5;
    localparam logic [2:0] PH_BARE   = 3'd6;
    localparam logic [2:0] PH_DONE   = 3'd7;

    localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

    logic [2:0]       phase_reg, phase_next;
    logic [15:0]      depth_reg, depth_next;
    logic             kind_reg, kind_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] lim;
    logic             emit_req, emit_ok, fin, fnd;
    logic [LEN_W-1:0] cnt_after;
    logic [CH_W-1:0]  opn, cls;
    res_t             byte_res, stat_res;

    function automatic logic is_ws(logic [CH_W-1:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    always_comb
    begin
        if (int'(value_limit) > VALUE_MAX) begin
            lim = LEN_W'(VALUE_MAX);
        end else begin
            lim = value_limit;
        end
    end

    assign opn = kind_reg ? CH_LBRACK : CH_LBRACE;
    assign cls = kind_reg ? CH_RBRACK : CH_RBRACE;

    always_comb
    begin
        phase_next = phase_reg;
        depth_next = depth_reg;
        kind_next  = kind_reg;
        emit_req   = 1'b0;
        fin        = 1'b0;
        fnd        = 1'b0;
        if (ch == CH_NUL) begin
            fin        = (phase_reg != PH_DONE);
            fnd        = (phase_reg == PH_PREVAL) || (phase_reg == PH_NEST) ||
                         (phase_reg == PH_BARE);
        end else begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (match) begin
                        phase_next = PH_COLON;
                    end
                end
                PH_COLON:
                begin
                    if (ch == CH_COLON) begin
                        phase_next = PH_PREVAL;
                    end else if (!is_ws(ch)) begin
                        fin = 1'b1;
                    end
                end
                PH_PREVAL:
                begin
                    if (is_ws(ch)) begin
                        phase_next = PH_PREVAL;
                    end else if (ch == CH_QUOTE) begin
                        phase_next = PH_STRING;
                    end else if (ch == CH_LBRACE || ch == CH_LBRACK) begin
                        kind_next  = (ch == CH_LBRACK);
                        depth_next = 16'd1;
                        emit_req   = 1'b1;
                        phase_next = PH_NEST;
                    end else if (ch == CH_COMMA || ch == CH_RBRACE || ch == CH_RBRACK) begin
                        fin = 1'b1;
                        fnd = 1'b1;
                    end else begin
                        emit_req   = 1'b1;
                        phase_next = PH_BARE;
                    end
                end
                PH_STRING:
                begin
                    if (ch == CH_QUOTE) begin
                        fin = 1'b1;
                        fnd = 1'b1;
                    end else begin
                        emit_req = 1'b1;
                        if (ch == CH_BSLASH) begin
                            phase_next = PH_ESCAPE;
                        end
                    end
                end
                PH_ESCAPE:
                begin
                    emit_req   = 1'b1;
                    phase_next = PH_STRING;
                end
                PH_NEST:
                begin
                    emit_req = 1'b1;
                    if (ch == opn) begin
                        if (depth_reg != DEPTH_MAX) begin
                            depth_next = depth_reg + 16'd1;
                        end
                    end else if (ch == cls) begin
                        if (depth_reg != 16'd0) begin
                            depth_next = depth_reg - 16'd1;
                        end
                        if (depth_next == 16'd0) begin
                            fin = 1'b1;
                            fnd = 1'b1;
                        end
                    end
                end
                PH_BARE:
                begin
                    if (ch == CH_COMMA || ch == CH_RBRACE || ch == CH_RBRACK || is_ws(ch)) begin
                        fin = 1'b1;
                        fnd = 1'b1;
                    end else begin
                        emit_req = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (fin) begin
                phase_next = PH_DONE;
            end
        end
    end

    assign emit_ok   = emit_req && (cnt_reg < lim);
    assign cnt_after = emit_ok ? cnt_reg + LEN_W'(1) : cnt_reg;

    always_comb
    begin
        byte_res              = '0;
        byte_res.value_byte   = ch;
        stat_res              = '0;
        stat_res.is_status    = 1'b1;
        stat_res.found        = fnd;
        stat_res.value_length = cnt_after;
        stat_res.last         = 1'b1;
    end

    always_comb
    begin
        push = '0;
        if (process) begin
            if (emit_ok && fin) begin
                push.n  = 2'd2;
                push.r0 = byte_res;
                push.r1 = stat_res;
            end else if (emit_ok) begin
                push.n  = 2'd1;
                push.r0 = byte_res;
            end else if (fin) begin
                push.n  = 2'd1;
                push.r0 = stat_res;
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_after;
        if (ch == CH_NUL) begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_SEARCH;
            depth_reg <= '0;
            kind_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else if (process) begin
            if (ch == CH_NUL) begin
                phase_reg <= PH_SEARCH;
                depth_reg <= '0;
                kind_reg  <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                depth_reg <= depth_next;
                kind_reg  <= kind_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    a_nest_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_NEST |-> depth_reg != 16'd0)
        else $error("nest depth is zero inside a nested value");

    a_pair_only_in_nest: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> phase_reg == PH_NEST)
        else $error("two results outside a nested value");

    a_status_moves_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0 && (push.r0.is_status || push.n == 2'd2))
        |=> (phase_reg == PH_DONE || phase_reg == PH_SEARCH))
        else $error("status issued but phase did not close");

endmodule

/* rtl/jkv_out_fifo.sv */
// ----------------------------------------------------------------------------
// jkv_out_fifo
// Four-entry result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module jkv_out_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  jkv_pkg::push_t             push,
    input  logic                       pop,
    output logic                       room,
    output logic                       head_valid,
    output jkv_pkg::res_t              head
);
    import jkv_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    res_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign room       = (int'(cnt_reg) <= DEPTH - 2);
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + PW'(push.n);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign cnt_next    = cnt_reg + CW'(push.n) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_ptr_reg + PW'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> (int'(cnt_reg) + int'(push.n)) <= DEPTH)
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("result queue read while empty");

endmodule

/* rtl/json_key_value_extractor.sv */
// ----------------------------------------------------------------------------
// json_key_value_extractor
// Finds a configured quoted key in a JSON byte stream and streams its value
// followed by one status transaction per document.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid / in_ready      ch
//   out      output     out_valid / out_ready    value_byte, is_status, found,
//                                                value_length, last
//   cfg      input      cfg_wr_en                cfg_index, cfg_data
//
// One byte is taken per cycle while the queue has room; a result passes through
// the input register and the queue before it is taken. A closing bracket that
// ends a nested value can yield two results, and the four-entry result queue
// drains at most one per cycle, so a byte waits in the input register, with
// in_ready low, while the queue holds more than two results. Reset is immediate,
// with no clearing pass. A stalled output holds its transaction until out_ready.
// ----------------------------------------------------------------------------
module json_key_value_extractor #(
    parameter int KEY_MAX = jkv_pkg::KEY_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [jkv_pkg::CH_W-1:0]       ch,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [jkv_pkg::CH_W-1:0]       value_byte,
    output logic                           is_status,
    output logic                           found,
    output logic [jkv_pkg::LEN_W-1:0]      value_length,
    output logic                           last,
    input  logic                           cfg_wr_en,
    input  logic [jkv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jkv_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jkv_pkg::*;

    key_words_t        key_words_reg;
    logic [KLEN_W-1:0] key_length_reg;
    logic [LEN_W-1:0]  value_limit_reg;

    logic              in_vld_reg, in_vld_next;
    logic [CH_W-1:0]   ch_reg;
    logic              accept, process, room, match;
    push_t             push;
    res_t              head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_words_reg   <= '0;
            key_length_reg  <= '0;
            value_limit_reg <= VALUE_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_KEY_WORD0:   key_words_reg[0] <= cfg_data;
                CFG_KEY_WORD1:   key_words_reg[1] <= cfg_data;
                CFG_KEY_WORD2:   key_words_reg[2] <= cfg_data;
                CFG_KEY_WORD3:   key_words_reg[3] <= cfg_data;
                CFG_KEY_LENGTH:  key_length_reg   <= cfg_data[KLEN_W-1:0];
                CFG_VALUE_LIMIT: value_limit_reg  <= cfg_data[LEN_W-1:0];
                default:         key_length_reg   <= key_length_reg;
            endcase
        end
    end

    assign process  = in_vld_reg && room;
    assign in_ready = !in_vld_reg || process;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (process)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg <= ch;
        end
    end

    jkv_key_match #(
        .KEY_MAX(KEY_MAX)
    ) u_key_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .process    (process),
        .ch         (ch_reg),
        .key_words  (key_words_reg),
        .key_length (key_length_reg),
        .match      (match)
    );

    jkv_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .process     (process),
        .ch          (ch_reg),
        .match       (match),
        .value_limit (value_limit_reg),
        .push        (push)
    );

    jkv_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (out_valid && out_ready),
        .room       (room),
        .head_valid (out_valid),
        .head       (head)
    );

    assign value_byte   = head.value_byte;
    assign is_status    = head.is_status;
    assign found        = head.found;
    assign value_length = head.value_length;
    assign last         = head.last;

endmodule
